@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the rectangle table block.
// Used only by the top level; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/rtnsch_pkg.sv @@
// Shared types and codes for the rectangle table search block.
// No dependencies.
package rtnsch_pkg;

    localparam int ID_BITS  = 16;
    localparam int EXT_BITS = 17;
    localparam int CNT_BITS = 6;
    localparam int FLD_BITS = 16;

    typedef enum logic [3:0] {
        OP_INSERT    = 4'd0,
        OP_REMOVE_ID = 4'd1,
        OP_REMOVE_PT = 4'd2,
        OP_CLEAR     = 4'd3,
        OP_RANGE     = 4'd4,
        OP_LEFT      = 4'd5,
        OP_RIGHT     = 4'd6,
        OP_UP        = 4'd7,
        OP_DOWN      = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic contain;
        logic overlap;
        logic cand;
        logic better;
        logic id_match;
    } eval_flags_t;

endpackage

@@ hw/rtl/rtnsch_ram.sv @@
// Generic single write, single read RAM with registered read data.
// No dependencies.
module rtnsch_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/rtnsch_eval.sv @@
// Shared per-entry compare unit: containment, overlap, nearest key and compares.
// Depends on rtnsch_pkg.
module rtnsch_eval #(
    parameter int CB = 16
) (
    input  rtnsch_pkg::op_t               op,
    input  logic                          tb,
    input  logic [CB-1:0]                 e_x,
    input  logic [CB-1:0]                 e_y,
    input  logic [CB-1:0]                 e_w,
    input  logic [CB-1:0]                 e_h,
    input  logic [CB-1:0]                 e_ox,
    input  logic [rtnsch_pkg::ID_BITS-1:0] e_id,
    input  logic [CB-1:0]                 q_x,
    input  logic [CB-1:0]                 q_y,
    input  logic [CB-1:0]                 q_w,
    input  logic [CB-1:0]                 q_h,
    input  logic [rtnsch_pkg::ID_BITS-1:0] q_id,
    input  logic [CB:0]                   best,
    output logic [CB:0]                   right,
    output logic [CB:0]                   bottom,
    output logic [CB:0]                   key,
    output rtnsch_pkg::eval_flags_t       flags
);
    import rtnsch_pkg::*;

    logic [CB:0] ex, ey, qx, qy, qr, qb, pt;
    logic        xov, yov, below;

    assign ex     = {1'b0, e_x};
    assign ey     = {1'b0, e_y};
    assign qx     = {1'b0, q_x};
    assign qy     = {1'b0, q_y};
    assign right  = ex + {1'b0, e_w};
    assign bottom = ey + {1'b0, e_h};
    assign qr     = qx + {1'b0, q_w};
    assign qb     = qy + {1'b0, q_h};
    assign xov    = (ex <= qr) && (right >= qx);
    assign yov    = (ey <= qb) && (bottom >= qy);

    always_comb begin
        // below: candidate lies under the query point, best is the greatest
        key   = ey;
        pt    = qy;
        below = 1'b0;
        case (op)
            OP_LEFT: begin
                key   = tb ? {1'b0, e_ox} : right;
                pt    = qx;
                below = 1'b1;
            end
            OP_RIGHT: begin
                key = tb ? {1'b0, e_ox} : ex;
                pt  = qx;
            end
            OP_UP: begin
                key   = bottom;
                below = 1'b1;
            end
            default: begin
                key = ey;
            end
        endcase
        flags.cand     = below ? (key < pt) : (key > pt);
        flags.better   = below ? (key > best) : (key < best);
        flags.contain  = (e_w != '0) && (e_h != '0) && (qx >= ex) && (qx < right) &&
                         (qy >= ey) && (qy < bottom);
        flags.overlap  = (xov && yov) || ((e_w == '0) && yov) || ((e_h == '0) && xov);
        flags.id_match = (e_id == q_id);
    end
endmodule

@@ hw/rtl/rect_table_range_nearest_search_top.sv @@
// Top level of the rectangle table: sequencer, table RAM and extent registers.
// Depends on rtnsch_pkg, rtnsch_ram, rtnsch_eval and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                                     | tuser     | tlast
//  s_axis  | in  | operation, pos_x, pos_y, size_w, size_h, orig_x, id    | time_based| -
//  m_axis  | out | found_id, extent_x, extent_y, entry_count              | status    | last
//
// Insert, clear, unknown codes and scans of an empty table go straight to the done
// state, which loads the result beat once the output register is free. Scans (remove,
// range, nearest) read one entry per cycle from the RAM, holding while a range match waits.
// Reset empties the table and zeroes both extents; no clearing pass is needed.
// s_axis_tready is high only while idle; a waiting result beat does not block it.
`include "assert_macros.svh"
module rect_table_range_nearest_search_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[3:0] pos_x[19:4] pos_y[35:20] size_w[51:36] size_h[67:52]
    // orig_x[83:68] entry_id[99:84], zero pad [103:100]
    input  logic [103:0] s_axis_tdata,
    // time_based[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found_id[15:0] extent_x[32:16] extent_y[49:33] entry_count[55:50]
    output logic [55:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import rtnsch_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EB = CB + 1;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XB = (CB > FLD_BITS) ? CB : FLD_BITS;
    localparam int OB = (EB > EXT_BITS) ? EB : EXT_BITS;
    localparam int CO = (CW > CNT_BITS) ? CW : CNT_BITS;
    localparam int RW = 5 * CB + ID_BITS;

    // input field decode, coordinates taken modulo 2^CB
    logic [XB-1:0] in_x_w, in_y_w, in_w_w, in_h_w, in_ox_w;
    logic [CB-1:0] in_x, in_y, in_w, in_h, in_ox;
    logic [ID_BITS-1:0] in_id;
    op_t in_op;

    assign in_op   = op_t'(s_axis_tdata[3:0]);
    assign in_x_w  = XB'(s_axis_tdata[19:4]);
    assign in_y_w  = XB'(s_axis_tdata[35:20]);
    assign in_w_w  = XB'(s_axis_tdata[51:36]);
    assign in_h_w  = XB'(s_axis_tdata[67:52]);
    assign in_ox_w = XB'(s_axis_tdata[83:68]);
    assign in_x    = in_x_w[CB-1:0];
    assign in_y    = in_y_w[CB-1:0];
    assign in_w    = in_w_w[CB-1:0];
    assign in_h    = in_h_w[CB-1:0];
    assign in_ox   = in_ox_w[CB-1:0];
    assign in_id   = s_axis_tdata[99:84];

    // registers
    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next, idx_reg, idx_next, wr_reg, wr_next;
    logic [EB-1:0] maxr_reg, maxr_next, maxb_reg, maxb_next;
    logic [EB-1:0] nr_reg, nr_next, nb_reg, nb_next, best_reg, best_next;
    logic [ID_BITS-1:0] bid_reg, bid_next, pend_id_reg, pend_id_next;
    logic [ID_BITS-1:0] res_id_reg, res_id_next, qid_reg, qid_next;
    logic [1:0] res_st_reg, res_st_next;
    logic hit_reg, hit_next, pend_reg, pend_next, tb_reg, tb_next;
    op_t op_reg, op_next;
    logic [CB-1:0] qx_reg, qx_next, qy_reg, qy_next, qw_reg, qw_next, qh_reg, qh_next;

    // output register
    logic ov_reg, olast_reg;
    logic [1:0] ost_reg;
    logic [ID_BITS-1:0] oid_reg;
    logic [EXT_BITS-1:0] oex_reg, oey_reg;
    logic [CNT_BITS-1:0] ocnt_reg;

    // RAM
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_q;

    // compare unit
    logic [EB-1:0] e_right, e_bottom, e_key;
    eval_flags_t flags;
    logic [ID_BITS-1:0] e_id;

    // control
    logic s_fire, o_free, stall, scan_end, scan_op, full, push, push_last;
    logic [ID_BITS-1:0] push_id;
    logic [1:0] push_st;
    logic [CW-1:0] idx_plus, cnt_m1;
    logic [OB-1:0] ex_wide, ey_wide;
    logic [CO-1:0] cnt_wide;
    logic [EB-1:0] ins_r, ins_b;

    assign e_id     = ram_q[RW-1 -: ID_BITS];
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign o_free   = !ov_reg || m_axis_tready;
    assign full     = (count_reg == CW'(TABLE_DEPTH));
    assign idx_plus = idx_reg + 1'b1;
    assign cnt_m1   = count_reg - 1'b1;
    assign stall    = (state_reg == ST_SCAN) && (op_reg == OP_RANGE) && flags.overlap &&
                      pend_reg && !o_free;
    assign scan_end = (state_reg == ST_SCAN) && !stall && (idx_reg == cnt_m1);
    assign scan_op  = (in_op == OP_REMOVE_ID) || (in_op == OP_REMOVE_PT) ||
                      (in_op == OP_RANGE) || (in_op == OP_LEFT) || (in_op == OP_RIGHT) ||
                      (in_op == OP_UP) || (in_op == OP_DOWN);
    assign ins_r    = {1'b0, in_x} + {1'b0, in_w};
    assign ins_b    = {1'b0, in_y} + {1'b0, in_h};
    assign ex_wide  = OB'(maxr_reg);
    assign ey_wide  = OB'(maxb_reg);
    assign cnt_wide = CO'(count_reg);

    rtnsch_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    rtnsch_eval #(.CB(CB)) u_eval (
        .op     (op_reg),
        .tb     (tb_reg),
        .e_x    (ram_q[CB-1:0]),
        .e_y    (ram_q[2*CB-1:CB]),
        .e_w    (ram_q[3*CB-1:2*CB]),
        .e_h    (ram_q[4*CB-1:3*CB]),
        .e_ox   (ram_q[5*CB-1:4*CB]),
        .e_id   (e_id),
        .q_x    (qx_reg),
        .q_y    (qy_reg),
        .q_w    (qw_reg),
        .q_h    (qh_reg),
        .q_id   (qid_reg),
        .best   (best_reg),
        .right  (e_right),
        .bottom (e_bottom),
        .key    (e_key),
        .flags  (flags)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (scan_op && count_reg != '0) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (o_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic keep, drop, upd, any;
        logic [CW-1:0] wr_fin;
        logic [EB-1:0] nr_acc, nb_acc;

        count_next = count_reg;  idx_next = idx_reg;   wr_next = wr_reg;
        maxr_next = maxr_reg;    maxb_next = maxb_reg; nr_next = nr_reg;
        nb_next = nb_reg;        best_next = best_reg; bid_next = bid_reg;
        pend_id_next = pend_id_reg; pend_next = pend_reg; hit_next = hit_reg;
        res_id_next = res_id_reg;   res_st_next = res_st_reg;
        qid_next = qid_reg; tb_next = tb_reg; op_next = op_reg;
        qx_next = qx_reg; qy_next = qy_reg; qw_next = qw_reg; qh_next = qh_reg;
        s_axis_tready = (state_reg == ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {in_id, in_ox, in_h, in_w, in_y, in_x};
        ram_raddr = '0;
        push = 1'b0; push_last = 1'b1; push_st = res_st_reg; push_id = res_id_reg;
        keep = 1'b0; drop = 1'b0; upd = 1'b0; any = 1'b0;
        wr_fin = wr_reg; nr_acc = nr_reg; nb_acc = nb_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next = in_op; tb_next = s_axis_tuser[0]; qid_next = in_id;
                    qx_next = in_x;  qy_next = in_y; qw_next = in_w; qh_next = in_h;
                    idx_next = '0; wr_next = '0; hit_next = 1'b0; pend_next = 1'b0;
                    nr_next = '0;  nb_next = '0; best_next = '0;  bid_next = '0;
                    res_st_next = STAT_NONE; res_id_next = '0;
                    case (in_op)
                        OP_INSERT: begin
                            if (full) begin
                                res_st_next = STAT_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                                res_st_next = STAT_OK;
                                if (ins_r > maxr_reg) begin
                                    maxr_next = ins_r;
                                end
                                if (ins_b > maxb_reg) begin
                                    maxb_next = ins_b;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            count_next  = '0;
                            res_st_next = STAT_OK;
                        end
                        default: res_st_next = STAT_NONE;
                    endcase
                end
            end
            ST_SCAN: begin
                ram_raddr = stall ? idx_reg[AW-1:0] : idx_plus[AW-1:0];
                ram_waddr = wr_reg[AW-1:0];
                ram_wdata = ram_q;
                if (!stall) begin
                    idx_next = idx_plus;
                    case (op_reg)
                        OP_REMOVE_ID: begin
                            keep = !flags.id_match;
                            if (!keep) begin
                                hit_next = 1'b1;
                            end
                            ram_we  = keep;
                            wr_fin  = keep ? wr_reg + 1'b1 : wr_reg;
                            wr_next = wr_fin;
                            if (scan_end) begin
                                if (hit_reg || !keep) begin
                                    count_next  = wr_fin;
                                    res_st_next = STAT_OK;
                                    res_id_next = qid_reg;
                                end
                            end
                        end
                        OP_REMOVE_PT: begin
                            drop   = flags.contain && !hit_reg;
                            keep   = !drop;
                            ram_we = keep;
                            if (keep) begin
                                wr_next = wr_reg + 1'b1;
                                if (e_right > nr_reg) begin
                                    nr_acc = e_right;
                                end
                                if (e_bottom > nb_reg) begin
                                    nb_acc = e_bottom;
                                end
                            end else begin
                                hit_next = 1'b1;
                                bid_next = e_id;
                            end
                            nr_next = nr_acc;
                            nb_next = nb_acc;
                            if (scan_end && (hit_reg || drop)) begin
                                count_next  = cnt_m1;
                                maxr_next   = nr_acc;
                                maxb_next   = nb_acc;
                                res_st_next = STAT_OK;
                                res_id_next = drop ? e_id : bid_reg;
                            end
                        end
                        OP_RANGE: begin
                            // one match held back so the final beat can carry last
                            if (flags.overlap) begin
                                if (pend_reg) begin
                                    push      = 1'b1;
                                    push_last = 1'b0;
                                    push_st   = STAT_OK;
                                    push_id   = pend_id_reg;
                                end
                                pend_next    = 1'b1;
                                pend_id_next = e_id;
                            end
                            if (scan_end) begin
                                any = flags.overlap || pend_reg;
                                res_st_next = any ? STAT_OK : STAT_NONE;
                                res_id_next = flags.overlap ? e_id :
                                              (pend_reg ? pend_id_reg : '0);
                            end
                        end
                        default: begin
                            upd = flags.cand && (!hit_reg || flags.better);
                            if (upd) begin
                                hit_next  = 1'b1;
                                best_next = e_key;
                                bid_next  = e_id;
                            end
                            if (scan_end) begin
                                any = hit_reg || upd;
                                res_st_next = any ? STAT_OK : STAT_NONE;
                                res_id_next = upd ? e_id : (hit_reg ? bid_reg : '0);
                            end
                        end
                    endcase
                end
            end
            ST_DONE: begin
                push = o_free;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            maxr_reg  <= '0;
            maxb_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            maxr_reg  <= maxr_next;
            maxb_reg  <= maxb_next;
            if (push) begin
                ov_reg <= 1'b1;
            end else if (m_axis_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // scan and payload registers, no reset needed
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;   wr_reg <= wr_next;     nr_reg <= nr_next;
        nb_reg <= nb_next;     best_reg <= best_next; bid_reg <= bid_next;
        pend_reg <= pend_next; pend_id_reg <= pend_id_next; hit_reg <= hit_next;
        res_id_reg <= res_id_next; res_st_reg <= res_st_next;
        qid_reg <= qid_next; tb_reg <= tb_next; op_reg <= op_next;
        qx_reg <= qx_next; qy_reg <= qy_next; qw_reg <= qw_next; qh_reg <= qh_next;
        if (push) begin
            ost_reg   <= push_st;
            oid_reg   <= push_id;
            olast_reg <= push_last;
            oex_reg   <= ex_wide[EXT_BITS-1:0];
            oey_reg   <= ey_wide[EXT_BITS-1:0];
            ocnt_reg  <= cnt_wide[CNT_BITS-1:0];
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {ocnt_reg, oey_reg, oex_reg, oid_reg};
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tlast  = olast_reg;

    // table never overfills
    `ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    // compaction write pointer never passes the read pointer
    `ASSERT_IMPLY(a_wr_behind, aclk, aresetn, state_reg == ST_SCAN, wr_reg <= idx_reg)
    // a stored insert grows the count by one
    `ASSERT_NEXT(a_insert_grows, aclk, aresetn, s_fire && in_op == OP_INSERT && !full,
                 count_reg == $past(count_reg) + 1'b1)
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking bench for the rectangle table search block.
// Drives op beats, predicts every result beat, and compares them field by field.
// Depends on rtnsch_pkg and rect_table_range_nearest_search_top.
module testbench;
    import rtnsch_pkg::*;

    localparam int DEPTH      = 32;
    localparam int RAND_ITEMS = 125;
    localparam int IDLE_LIMIT = 3000;
    localparam int MAX_SHOWN  = 10;
    localparam logic [3:0] OP_BAD_LO = 4'd9;
    localparam logic [3:0] OP_BAD_HI = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [15:0] x, y, w, h, ox, id;
        logic        tb;
        bit          typed;     // status/found_id below are fixed by hand
        logic [1:0]  status;
        logic [15:0] fid;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fid;
        logic        last;
        logic [16:0] ext_x, ext_y;
        logic [5:0]  count;
    } beat_t;

    typedef struct {
        logic [15:0] x, y, w, h, ox, id;
    } rect_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    rect_table_range_nearest_search_top u_top (.*);

    initial forever #5 aclk = ~aclk;

    // shadow of the table
    rect_t       tbl [DEPTH];
    int          n_rect = 0;
    logic [16:0] max_r = '0, max_b = '0;

    beat_t pending_beats [$];
    int    n_mismatch = 0;
    int    idle_cycles = 0;
    int    gap = 0;
    int    rx_stall = 0;
    bit    quiet = 0;    // run of back-to-back beats with no idling

    function automatic beat_t mk(logic [1:0] st, logic [15:0] fid, logic last);
        beat_t b;
        b.status = st; b.fid = fid; b.last = last;
        b.ext_x = max_r; b.ext_y = max_b; b.count = 6'(n_rect);
        return b;
    endfunction

    // Applies one command to the shadow table and queues the beats it yields.
    function automatic void table_apply(cmd_t c);
        longint unsigned px, py, key, best, r, b;
        longint unsigned ex, ey, ew, eh;
        logic [15:0] bid;
        bit have, cand, better, xov, yov;
        int j, hits;
        px = c.x; py = c.y;
        case (c.op)
            OP_INSERT: begin
                if (n_rect >= DEPTH) begin
                    pending_beats.push_back(mk(STAT_FULL, '0, 1'b1));
                end else begin
                    tbl[n_rect] = '{c.x, c.y, c.w, c.h, c.ox, c.id};
                    n_rect++;
                    r = px + c.w; b = py + c.h;
                    if (r > max_r) max_r = 17'(r);
                    if (b > max_b) max_b = 17'(b);
                    pending_beats.push_back(mk(STAT_OK, '0, 1'b1));
                end
            end
            OP_REMOVE_ID: begin
                j = 0; have = 0;
                for (int i = 0; i < n_rect; i++) begin
                    if (tbl[i].id == c.id) have = 1;
                    else begin tbl[j] = tbl[i]; j++; end
                end
                n_rect = j;
                pending_beats.push_back(mk(have ? STAT_OK : STAT_NONE,
                                           have ? c.id : 16'd0, 1'b1));
            end
            OP_REMOVE_PT: begin
                have = 0;
                for (int i = 0; i < n_rect && !have; i++) begin
                    ex = tbl[i].x; ey = tbl[i].y; ew = tbl[i].w; eh = tbl[i].h;
                    if (ew != 0 && eh != 0 && px >= ex && px <= ex + ew - 1 &&
                        py >= ey && py <= ey + eh - 1) begin
                        have = 1;
                        bid = tbl[i].id;
                        for (int k = i; k + 1 < n_rect; k++) tbl[k] = tbl[k + 1];
                        n_rect--;
                        max_r = '0; max_b = '0;
                        for (int k = 0; k < n_rect; k++) begin
                            r = longint'(tbl[k].x) + tbl[k].w;
                            b = longint'(tbl[k].y) + tbl[k].h;
                            if (r > max_r) max_r = 17'(r);
                            if (b > max_b) max_b = 17'(b);
                        end
                    end
                end
                pending_beats.push_back(mk(have ? STAT_OK : STAT_NONE,
                                           have ? bid : 16'd0, 1'b1));
            end
            OP_CLEAR: begin
                n_rect = 0;
                pending_beats.push_back(mk(STAT_OK, '0, 1'b1));
            end
            OP_RANGE: begin
                hits = 0;
                for (int i = 0; i < n_rect; i++) begin
                    ex = tbl[i].x; ey = tbl[i].y; ew = tbl[i].w; eh = tbl[i].h;
                    yov = (ey <= py + c.h) && (ey + eh >= py);
                    xov = (ex <= px + c.w) && (ex + ew >= px);
                    if ((xov && yov) || (ew == 0 && yov) || (eh == 0 && xov)) begin
                        pending_beats.push_back(mk(STAT_OK, tbl[i].id, 1'b0));
                        hits++;
                    end
                end
                if (hits == 0) pending_beats.push_back(mk(STAT_NONE, '0, 1'b1));
                else pending_beats[$].last = 1'b1;
            end
            OP_LEFT, OP_RIGHT, OP_UP, OP_DOWN: begin
                have = 0; best = 0; bid = '0;
                for (int i = 0; i < n_rect; i++) begin
                    case (c.op)
                        OP_LEFT: begin
                            key = c.tb ? longint'(tbl[i].ox)
                                       : longint'(tbl[i].x) + tbl[i].w;
                            cand = key < px; better = key > best;
                        end
                        OP_RIGHT: begin
                            key = c.tb ? tbl[i].ox : tbl[i].x;
                            cand = key > px; better = key < best;
                        end
                        OP_UP: begin
                            key = longint'(tbl[i].y) + tbl[i].h;
                            cand = key < py; better = key > best;
                        end
                        default: begin
                            key = tbl[i].y;
                            cand = key > py; better = key < best;
                        end
                    endcase
                    if (cand && (!have || better)) begin
                        have = 1; best = key; bid = tbl[i].id;
                    end
                end
                pending_beats.push_back(mk(have ? STAT_OK : STAT_NONE,
                                           have ? bid : 16'd0, 1'b1));
            end
            default: pending_beats.push_back(mk(STAT_NONE, '0, 1'b1));
        endcase
    endfunction

    // Offers one command beat after a random gap; predicts on acceptance.
    task automatic issue(cmd_t c);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, c.id, c.ox, c.h, c.w, c.y, c.x, c.op};
        s_axis_tuser  <= c.tb;
        do @(posedge aclk); while (!s_axis_tready);
        table_apply(c);
        // hand-typed expectation overrides the predicted code and id
        if (c.typed) begin
            pending_beats[$].status = c.status;
            pending_beats[$].fid    = c.fid;
        end
        if ($urandom_range(0, 19) == 0) quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 12);
    endtask

    function automatic cmd_t cmd(logic [3:0] op, logic [15:0] x, logic [15:0] y,
                                 logic [15:0] w, logic [15:0] h, logic [15:0] ox,
                                 logic [15:0] id, logic tb);
        cmd_t c;
        c = '{op, x, y, w, h, ox, id, tb, 1'b0, 2'd0, 16'd0};
        return c;
    endfunction

    function automatic cmd_t typed(cmd_t c, logic [1:0] st, logic [15:0] fid);
        c.typed = 1'b1; c.status = st; c.fid = fid;
        return c;
    endfunction

    // Mostly small coordinates so boxes touch; sometimes the whole range.
    function automatic logic [15:0] coord();
        return ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int pick;
        logic [3:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 35)      op = OP_INSERT;
        else if (pick < 42) op = OP_REMOVE_ID;
        else if (pick < 50) op = OP_REMOVE_PT;
        else if (pick < 52) op = OP_CLEAR;
        else if (pick < 70) op = OP_RANGE;
        else if (pick < 96) op = 4'($urandom_range(OP_LEFT, OP_DOWN));
        else                op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        c = cmd(op, coord(), coord(), coord(), coord(), coord(),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)),
                1'($urandom));
        // zero sizes often enough to hit the unlimited cases
        if ($urandom_range(0, 7) == 0) c.w = '0;
        if ($urandom_range(0, 7) == 0) c.h = '0;
        return c;
    endfunction

    function automatic cmd_t with_op_insert(int n);
        cmd_t c;
        c = rand_cmd();
        c.op = OP_INSERT;
        c.id = 16'(n + 1);
        return c;
    endfunction

    // Result side: random stall per beat, compare with the oldest prediction.
    always @(posedge aclk) begin
        beat_t exp_b, got;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tlast,
                        m_axis_tdata[32:16], m_axis_tdata[49:33], m_axis_tdata[55:50]};
                if (pending_beats.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_SHOWN)
                        $display("unexpected result beat: st=%0d id=%h", got.status, got.fid);
                end else begin
                    exp_b = pending_beats.pop_front();
                    if (got !== exp_b) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_SHOWN)
                            $display("beat mismatch exp st=%0d id=%h l=%b ex=%h ey=%h n=%0d %s",
                                     exp_b.status, exp_b.fid, exp_b.last, exp_b.ext_x,
                                     exp_b.ext_y, exp_b.count, "");
                        if (n_mismatch <= MAX_SHOWN)
                            $display("               got st=%0d id=%h l=%b ex=%h ey=%h n=%0d",
                                     got.status, got.fid, got.last, got.ext_x,
                                     got.ext_y, got.count);
                    end
                end
                rx_stall = quiet ? 0 : $urandom_range(0, 12);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_axis_tready <= (rx_stall == 0);
        end
    end

    // Watchdog: too long without any beat on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        cmd_t dir_tab [$];
        dir_tab.push_back(typed(cmd(OP_RANGE, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0),
                                STAT_NONE, 0));                 // empty table
        dir_tab.push_back(typed(cmd(OP_LEFT, 16'hFFFF, 0, 0, 0, 0, 0, 0), STAT_NONE, 0));
        dir_tab.push_back(typed(cmd(OP_INSERT, 0, 0, 0, 0, 0, 16'd1, 0), STAT_OK, 0));
        dir_tab.push_back(typed(cmd(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 1), STAT_OK, 0));  // top extents
        dir_tab.push_back(cmd(OP_INSERT, 10, 10, 0, 20, 7, 16'd2, 0));    // no width
        dir_tab.push_back(cmd(OP_INSERT, 100, 5, 30, 0, 900, 16'd3, 0));  // no height
        dir_tab.push_back(cmd(OP_INSERT, 20, 20, 10, 10, 500, 16'd4, 0));
        dir_tab.push_back(cmd(OP_INSERT, 20, 40, 10, 10, 500, 16'd5, 0)); // tie on orig x
        dir_tab.push_back(cmd(OP_RANGE, 0, 0, 50, 50, 0, 0, 0));
        dir_tab.push_back(cmd(OP_RANGE, 200, 12, 5, 3, 0, 0, 0));
        dir_tab.push_back(cmd(OP_LEFT, 200, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(cmd(OP_LEFT, 600, 0, 0, 0, 0, 0, 1));
        dir_tab.push_back(cmd(OP_RIGHT, 5, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(cmd(OP_RIGHT, 100, 0, 0, 0, 0, 0, 1));
        dir_tab.push_back(cmd(OP_UP, 0, 45, 0, 0, 0, 0, 0));
        dir_tab.push_back(cmd(OP_DOWN, 0, 5, 0, 0, 0, 0, 0));
        dir_tab.push_back(typed(cmd(OP_REMOVE_PT, 25, 25, 0, 0, 0, 0, 0), STAT_OK, 16'd4));
        dir_tab.push_back(typed(cmd(OP_REMOVE_PT, 10, 15, 0, 0, 0, 0, 0), STAT_NONE, 0));
        dir_tab.push_back(typed(cmd(OP_REMOVE_ID, 0, 0, 0, 0, 0, 16'd2, 0), STAT_OK, 16'd2));
        dir_tab.push_back(typed(cmd(OP_REMOVE_ID, 0, 0, 0, 0, 0, 16'd2, 0), STAT_NONE, 0));
        dir_tab.push_back(typed(cmd(OP_BAD_LO, 1, 1, 1, 1, 1, 1, 1), STAT_NONE, 0));
        dir_tab.push_back(typed(cmd(OP_BAD_HI, 0, 0, 0, 0, 0, 0, 0), STAT_NONE, 0));
        dir_tab.push_back(typed(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), STAT_OK, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) issue(dir_tab[i]);
        // fill to the brim, then one insert too many
        for (int i = 0; i < DEPTH; i++) issue(with_op_insert(i));
        issue(typed(cmd(OP_INSERT, 1, 1, 1, 1, 1, 16'd9, 0), STAT_FULL, 0));
        issue(cmd(OP_RANGE, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0));   // up to 32 beats
        issue(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < RAND_ITEMS; i++) issue(rand_cmd());
        s_axis_tvalid <= 1'b0;

        wait (pending_beats.size() == 0);
        repeat (60) @(posedge aclk);
        if (n_mismatch == 0 && pending_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
